>>> design/sgd_momentum_update_defines.svh
// Assertion macros shared by the sgd momentum update checkers.
`ifndef SGD_MOMENTUM_UPDATE_DEFINES_SVH
`define SGD_MOMENTUM_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGDMU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGDMU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Holds in the cycle after any cycle with reset asserted.
`define SGDMU_ASSERT_AFTER_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) (!(rstn)) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sgdmu_pkg.sv
// Shared constants, register codes and word types of the sgd momentum update block.
`timescale 1ns / 1ps

package sgdmu_pkg;

    localparam int IDX_W               = 12;
    localparam int VALUE_W             = 32;
    localparam int RATE_W              = 24;
    localparam int MOM_W               = 16;
    localparam int CFG_IDX_W           = 1;
    localparam int CFG_DATA_W          = 24;
    localparam int DEFAULT_PARAM_DEPTH = 4096;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(167772);
    localparam logic [MOM_W-1:0]  MOM_RESET  = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_RATE      = 1'b0,
        REG_MOMENTUM_COEFF = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0]          param_index;
        logic signed [VALUE_W-1:0] weight_in;
        logic signed [VALUE_W-1:0] gradient;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] weight_out;
        logic                      saturated;
    } out_word_t;

endpackage

>>> design/sgd_momentum_update.sv
// SGD-with-momentum update: one parameter word in, one updated weight word out.
// Throughput one word per cycle unless m_ready back-pressure or a hazard stalls it.
// With momentum on, a word whose velocity address equals that of the word directly
// ahead waits in stage 1 while that word is in stage 2, as its new velocity is not yet
// registered. Reset restores the register defaults, then zeroes the velocity RAM
// one entry per cycle with s_ready held low; config writes are taken meanwhile.
`timescale 1ns / 1ps

module sgd_momentum_update
    import sgdmu_pkg::*;
#(
    parameter int PARAM_DEPTH = DEFAULT_PARAM_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int ADDR_W   = $clog2(PARAM_DEPTH);
    localparam int RECIP_SH = 24;
    // ceil(2^24 / depth): exact quotient for any 12-bit index
    localparam int RECIP    = (2**RECIP_SH + PARAM_DEPTH - 1) / PARAM_DEPTH;
    localparam int QP_W     = IDX_W + RECIP_SH;
    localparam logic [IDX_W-1:0]  DEPTH_LOW = IDX_W'(PARAM_DEPTH % (2**IDX_W));
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PARAM_DEPTH - 1);

    localparam int RHALF    = RATE_W / 2;
    localparam int PP_W     = VALUE_W + RHALF + 1;
    localparam int RTS_W    = PP_W + RHALF + 1;
    localparam int RT_ROUND = 2**(RATE_W - 1);
    localparam int MP_W     = VALUE_W + MOM_W + 1;
    localparam int VS_W     = MP_W + 1;
    localparam int MP_ROUND = 2**(MOM_W - 1);

    localparam logic signed [VALUE_W+1:0] VAL_MAX = {3'b000, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W+1:0] VAL_MIN = {3'b111, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      clipped;
    } clip_t;

    function automatic clip_t clip_value(input logic signed [VALUE_W+1:0] x);
        clip_t c;
        if (x > VAL_MAX) begin
            c.value   = VAL_MAX[VALUE_W-1:0];
            c.clipped = 1'b1;
        end else if (x < VAL_MIN) begin
            c.value   = VAL_MIN[VALUE_W-1:0];
            c.clipped = 1'b1;
        end else begin
            c.value   = x[VALUE_W-1:0];
            c.clipped = 1'b0;
        end
        return c;
    endfunction

    // configuration
    logic [RATE_W-1:0] rate_reg;
    logic [MOM_W-1:0]  mom_reg;
    logic              mom_nz;

    // flow control
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic take0, take1, take2, take3, take4, take5;
    logic move1, haz;

    // velocity clearing sweep
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // stage 0: accepted word
    logic [IDX_W-1:0]          idx0_reg;
    logic signed [VALUE_W-1:0] w0_reg, g0_reg;
    logic [QP_W-1:0]           qprod;
    logic [IDX_W-1:0]          q_next;
    logic signed [PP_W-1:0]    g_ext, phi_next, plo_next;

    // stage 1: address reduction, rate term
    logic [IDX_W-1:0]          idx1_reg, q1_reg, r1;
    logic signed [VALUE_W-1:0] w1_reg;
    logic signed [PP_W-1:0]    phi1_reg, plo1_reg;
    logic signed [RTS_W-1:0]   rts;
    logic signed [VALUE_W-1:0] rt_next;
    logic [ADDR_W-1:0]         addr1;
    logic                      ovr_valid_next;
    logic signed [VALUE_W-1:0] ovr_data_next;

    // stage 2: velocity read, momentum product
    logic [ADDR_W-1:0]         addr2_reg;
    logic signed [VALUE_W-1:0] w2_reg, rt2_reg, ovr_data_reg, vold;
    logic                      ovr_valid_reg;
    logic signed [MP_W-1:0]    mp_next;

    // stage 3: new velocity
    logic [ADDR_W-1:0]         addr3_reg;
    logic signed [VALUE_W-1:0] w3_reg, rt3_reg, delta_next;
    logic signed [MP_W-1:0]    mp3_reg;
    logic signed [VS_W-1:0]    vsum;
    clip_t                     vclip;
    logic                      satv_next;

    // stage 4: weight update, velocity write-back
    logic [ADDR_W-1:0]         addr4_reg;
    logic signed [VALUE_W-1:0] w4_reg, delta4_reg;
    logic                      satv4_reg;
    logic signed [VALUE_W+1:0] wdiff;
    clip_t                     wclip;

    out_word_t out_data_reg;

    // RAM ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;

    assign mom_nz = (mom_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
            mom_reg  <= MOM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEP_RATE:      rate_reg <= cfg_wr_data[RATE_W-1:0];
                REG_MOMENTUM_COEFF: mom_reg  <= cfg_wr_data[MOM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Stage handshake: a stage loads when empty or when its word moves on.
    // With momentum on, a word may not enter stage 2 while one with its address sits there.
    always_comb begin
        take5 = !out_valid_reg || m_ready;
        take4 = !v4_reg || take5;
        take3 = !v3_reg || take4;
        take2 = !v2_reg || take3;
        haz   = mom_nz && v1_reg && v2_reg && (addr1 == addr2_reg);
        move1 = v1_reg && take2 && !haz;
        take1 = !v1_reg || (take2 && !haz);
        take0 = !v0_reg || take1;
    end

    assign s_ready = take0 && !clearing_reg;

    // stage 0 arithmetic
    always_comb begin
        qprod    = QP_W'(idx0_reg) * QP_W'(RECIP);
        q_next   = qprod[QP_W-1:RECIP_SH];
        g_ext    = PP_W'(g0_reg);
        phi_next = g_ext * $signed(PP_W'(rate_reg[RATE_W-1:RHALF]));
        plo_next = g_ext * $signed(PP_W'(rate_reg[RHALF-1:0]));
    end

    // stage 1 arithmetic
    always_comb begin
        r1      = idx1_reg - IDX_W'(q1_reg * DEPTH_LOW);
        addr1   = ADDR_W'(r1);
        rts     = (RTS_W'(phi1_reg) <<< RHALF) + RTS_W'(plo1_reg) + RTS_W'(RT_ROUND);
        rt_next = $signed(rts[RATE_W +: VALUE_W]);
        // velocity still in flight ahead: the younger of stages 3 and 4 wins
        ovr_valid_next = mom_nz && ((v3_reg && (addr3_reg == addr1)) ||
                                    (v4_reg && (addr4_reg == addr1)));
        ovr_data_next  = (v3_reg && (addr3_reg == addr1)) ? vclip.value : delta4_reg;
    end

    // stage 2 arithmetic
    always_comb begin
        vold    = ovr_valid_reg ? ovr_data_reg : $signed(ram_rdata);
        mp_next = MP_W'(vold) * $signed(MP_W'(mom_reg));
    end

    // stage 3 arithmetic: rounding and sum folded into one add
    always_comb begin
        vsum       = VS_W'(mp3_reg) + (VS_W'(rt3_reg) <<< MOM_W) + VS_W'(MP_ROUND);
        vclip      = clip_value($signed(vsum[MOM_W +: VALUE_W+2]));
        delta_next = mom_nz ? vclip.value : rt3_reg;
        satv_next  = mom_nz && vclip.clipped;
    end

    // stage 4 arithmetic
    always_comb begin
        wdiff = (VALUE_W+2)'(w4_reg) - (VALUE_W+2)'(delta4_reg);
        wclip = clip_value(wdiff);
    end

    always_comb begin
        ram_we    = clearing_reg || (v4_reg && take5 && mom_nz);
        ram_waddr = clearing_reg ? clr_addr_reg : addr4_reg;
        ram_wdata = clearing_reg ? '0 : delta4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end else begin
            if (take0) begin
                v0_reg <= s_valid && s_ready;
            end
            if (take1) begin
                v1_reg <= v0_reg;
            end
            if (take2) begin
                v2_reg <= move1;
            end
            if (take3) begin
                v3_reg <= v2_reg;
            end
            if (take4) begin
                v4_reg <= v3_reg;
            end
            if (take5) begin
                out_valid_reg <= v4_reg;
            end
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take0) begin
            idx0_reg <= s_data.param_index;
            w0_reg   <= s_data.weight_in;
            g0_reg   <= s_data.gradient;
        end
        if (take1) begin
            idx1_reg <= idx0_reg;
            q1_reg   <= q_next;
            w1_reg   <= w0_reg;
            phi1_reg <= phi_next;
            plo1_reg <= plo_next;
        end
        if (take2) begin
            addr2_reg     <= addr1;
            w2_reg        <= w1_reg;
            rt2_reg       <= rt_next;
            ovr_valid_reg <= ovr_valid_next;
            ovr_data_reg  <= ovr_data_next;
        end
        if (take3) begin
            addr3_reg <= addr2_reg;
            w3_reg    <= w2_reg;
            rt3_reg   <= rt2_reg;
            mp3_reg   <= mp_next;
        end
        if (take4) begin
            addr4_reg  <= addr3_reg;
            w4_reg     <= w3_reg;
            delta4_reg <= delta_next;
            satv4_reg  <= satv_next;
        end
        if (take5) begin
            out_data_reg.weight_out <= wclip.value;
            out_data_reg.saturated  <= satv4_reg || wclip.clipped;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // read data is held while stage 2 is stalled
    sgdmu_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (PARAM_DEPTH)
    ) u_velocity_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (take2),
        .rd_addr (addr1),
        .rd_data (ram_rdata)
    );

endmodule

>>> design/sgdmu_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module sgdmu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents when both ports hit the same entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/sgdmu_checker.sv
// Port-level checker for the sgd momentum update block, bound to the top level.
`timescale 1ns / 1ps
`include "sgd_momentum_update_defines.svh"

module sgdmu_checker
    import sgdmu_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // words the pipeline can hold: five stages plus the output register
    localparam int PIPE_DEPTH = 6;
    localparam int PEND_W     = $clog2(PIPE_DEPTH + 1);

    logic [PEND_W-1:0] pending_reg;
    logic              in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            unique case ({in_acc, out_acc})
                2'b10:   pending_reg <= pending_reg + PEND_W'(1);
                2'b01:   pending_reg <= pending_reg - PEND_W'(1);
                default: pending_reg <= pending_reg;
            endcase
        end
    end

    `SGDMU_ASSERT_AFTER_RESET(a_ready_low_after_reset, aclk, aresetn, !s_ready, "s_ready high during velocity clear")
    `SGDMU_ASSERT_AFTER_RESET(a_no_result_after_reset, aclk, aresetn, !m_valid, "m_valid high straight after reset")
    `SGDMU_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result word changed")
    `SGDMU_ASSERT_NOW(a_result_has_source, aclk, aresetn, m_valid, pending_reg != '0, "result word without an input word")
    `SGDMU_ASSERT_NOW(a_pending_bounded, aclk, aresetn, 1'b1, pending_reg <= PEND_W'(PIPE_DEPTH), "more words in flight than pipeline stages")

endmodule

bind sgd_momentum_update sgdmu_checker u_sgdmu_checker (.*);
